// ===== hw/rtl/ple_pkg.sv =====
// Shared constants, codes and control/status types of the positional list engine.
package ple_pkg;

	localparam int PLE_CAPACITY   = 16;
	localparam int PLE_DATA_WIDTH = 32;

	localparam int OP_W    = 3;
	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;

	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
	localparam logic [OP_W-1:0] OP_GET    = 3'd1;
	localparam logic [OP_W-1:0] OP_LOCATE = 3'd2;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	localparam logic [2:0] IDX_HOLD  = 3'd0;
	localparam logic [2:0] IDX_ZERO  = 3'd1;
	localparam logic [2:0] IDX_COUNT = 3'd2;
	localparam logic [2:0] IDX_POS   = 3'd3;
	localparam logic [2:0] IDX_INC   = 3'd4;
	localparam logic [2:0] IDX_DEC   = 3'd5;

	localparam logic [1:0] RA_IDX    = 2'd0;
	localparam logic [1:0] RA_IDX_M1 = 2'd1;
	localparam logic [1:0] RA_IDX_P1 = 2'd2;
	localparam logic [1:0] RA_POS    = 2'd3;

	localparam logic WR_RDATA = 1'b0;
	localparam logic WR_VALUE = 1'b1;

	localparam logic [1:0] CNT_HOLD  = 2'd0;
	localparam logic [1:0] CNT_CLEAR = 2'd1;
	localparam logic [1:0] CNT_INC   = 2'd2;
	localparam logic [1:0] CNT_DEC   = 2'd3;

	typedef struct packed {
		logic              load_in;
		logic [2:0]        idx_op;
		logic              rd_en;
		logic [1:0]        rd_sel;
		logic              wr_en;
		logic              wr_sel;
		logic [1:0]        cnt_op;
		logic              st_set;
		logic [STAT_W-1:0] st_code;
		logic              ov_load;
		logic              fp_load;
		logic              res_load;
	} ple_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            get_bad;
		logic            ins_bad;
		logic            full;
		logic            cnt_zero;
		logic            ins_at;
		logic            at_last;
		logic            match;
	} ple_stat_t;

endpackage

// ===== hw/rtl/ple_datapath.sv =====
// Datapath of the positional list engine: entry memory, count, index and result registers.
module ple_datapath
	import ple_pkg::*;
#(
	parameter int CAPACITY   = PLE_CAPACITY,
	parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ple_cmd_t                cmd,
	output ple_stat_t               stat,
	input  logic [OP_W-1:0]         op,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic [STAT_W-1:0]       status,
	output logic signed [VAL_W-1:0] out_value,
	output logic [POS_W-1:0]        found_position,
	output logic [POS_W-1:0]        list_length,
	output logic                    is_empty
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [DATA_WIDTH-1:0] mem [CAPACITY];

	logic [OP_W-1:0]       op_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         idx_q;
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [STAT_W-1:0]     st_w_q;
	logic [DATA_WIDTH-1:0] ov_w_q;
	logic [POS_W-1:0]      fp_w_q;

	logic [STAT_W-1:0]     st_q;
	logic [DATA_WIDTH-1:0] ov_q;
	logic [POS_W-1:0]      fp_q;
	logic [CW-1:0]         len_q;

	logic [XW-1:0] pos_x, cnt_x, idx_x;
	logic [AW-1:0] pos_m1, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(count_q);
	assign idx_x  = XW'(idx_q);
	assign pos_m1 = AW'(pos_x - XW'(1));

	always_comb begin
		stat.op       = op_q;
		stat.get_bad  = (pos_x == '0) || (pos_x > cnt_x);
		stat.ins_bad  = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
		stat.full     = cnt_x >= XW'(CAPACITY);
		stat.cnt_zero = count_q == '0;
		stat.ins_at   = (idx_x + XW'(1)) == pos_x;
		stat.at_last  = (idx_x + XW'(1)) >= cnt_x;
		stat.match    = rdata_q == val_q;
	end

	always_comb begin
		case (cmd.rd_sel)
			RA_IDX:    rd_addr = idx_q;
			RA_IDX_M1: rd_addr = AW'(idx_q - AW'(1));
			RA_IDX_P1: rd_addr = AW'(idx_q + AW'(1));
			RA_POS:    rd_addr = pos_m1;
			default:   rd_addr = idx_q;
		endcase
	end

	assign wr_data = (cmd.wr_sel == WR_VALUE) ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[idx_q] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_CLEAR: count_q <= '0;
				CNT_INC:   count_q <= count_q + CW'(1);
				CNT_DEC:   count_q <= count_q - CW'(1);
				default:   count_q <= count_q;
			endcase
			case (cmd.idx_op)
				IDX_ZERO:  idx_q <= '0;
				IDX_COUNT: idx_q <= AW'(count_q);
				IDX_POS:   idx_q <= pos_m1;
				IDX_INC:   idx_q <= AW'(idx_q + AW'(1));
				IDX_DEC:   idx_q <= AW'(idx_q - AW'(1));
				default:   idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= op;
			pos_q  <= position;
			val_q  <= DATA_WIDTH'(value);
			st_w_q <= ST_OK;
			ov_w_q <= '0;
			fp_w_q <= '0;
		end else begin
			if (cmd.st_set) begin
				st_w_q <= cmd.st_code;
			end
			if (cmd.ov_load) begin
				ov_w_q <= rdata_q;
			end
			if (cmd.fp_load) begin
				fp_w_q <= POS_W'(idx_x + XW'(1));
			end
		end
		if (cmd.res_load) begin
			st_q  <= st_w_q;
			ov_q  <= ov_w_q;
			fp_q  <= fp_w_q;
			len_q <= count_q;
		end
	end

	assign status         = st_q;
	assign out_value      = VAL_W'(ov_q);
	assign found_position = fp_q;
	assign list_length    = POS_W'(len_q);
	assign is_empty       = len_q == '0;

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
// Controller of the positional list engine: sequences memory reads, shifts and result hand-off.
module ple_ctrl
	import ple_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ple_stat_t stat,
	output ple_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_GET_WAIT = 4'd2;
	localparam logic [3:0] S_SCAN_RD  = 4'd3;
	localparam logic [3:0] S_SCAN_CMP = 4'd4;
	localparam logic [3:0] S_INS_CHK  = 4'd5;
	localparam logic [3:0] S_INS_WR   = 4'd6;
	localparam logic [3:0] S_DEL_CAP  = 4'd7;
	localparam logic [3:0] S_DEL_CHK  = 4'd8;
	localparam logic [3:0] S_DEL_WR   = 4'd9;
	localparam logic [3:0] S_FINISH   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					OP_CLEAR: begin
						cmd.cnt_op = CNT_CLEAR;
						state_d    = S_FINISH;
					end
					OP_GET: begin
						if (stat.get_bad) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_BADPOS;
							state_d     = S_FINISH;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_POS;
							state_d    = S_GET_WAIT;
						end
					end
					OP_LOCATE: begin
						cmd.st_set  = 1'b1;
						cmd.st_code = ST_NOTFOUND;
						cmd.idx_op  = IDX_ZERO;
						state_d     = stat.cnt_zero ? S_FINISH : S_SCAN_RD;
					end
					OP_INSERT: begin
						if (stat.full) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_FULL;
							state_d     = S_FINISH;
						end else if (stat.ins_bad) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_BADPOS;
							state_d     = S_FINISH;
						end else begin
							cmd.idx_op = IDX_COUNT;
							state_d    = S_INS_CHK;
						end
					end
					OP_DELETE: begin
						if (stat.get_bad) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_BADPOS;
							state_d     = S_FINISH;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_POS;
							cmd.idx_op = IDX_POS;
							state_d    = S_DEL_CAP;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_GET_WAIT: begin
				cmd.ov_load = 1'b1;
				state_d     = S_FINISH;
			end
			S_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_IDX;
				state_d    = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (stat.match) begin
					cmd.st_set  = 1'b1;
					cmd.st_code = ST_OK;
					cmd.fp_load = 1'b1;
					state_d     = S_FINISH;
				end else if (stat.at_last) begin
					state_d = S_FINISH;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = S_SCAN_RD;
				end
			end
			S_INS_CHK: begin
				// drop the new value into its slot once the tail has moved up
				if (stat.ins_at) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_VALUE;
					cmd.cnt_op = CNT_INC;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX_M1;
					state_d    = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_RDATA;
				cmd.idx_op = IDX_DEC;
				state_d    = S_INS_CHK;
			end
			S_DEL_CAP: begin
				cmd.ov_load = 1'b1;
				state_d     = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				if (stat.at_last) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX_P1;
					state_d    = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_RDATA;
				cmd.idx_op = IDX_INC;
				state_d    = S_DEL_CHK;
			end
			S_FINISH: begin
				// hold here until the output register is free
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/positional_list_engine_top.sv =====
// Sequence: accept, decode, then the operation, then register the result once the output is free.
// Clear and rejected items go from decode straight to the result; get reads one entry; locate reads
// and compares each entry in turn; insert moves entries up one by one, delete moves them down one by one.
// Throughput: one item at a time, paced by the entry memory, used for one read or write a cycle.
// The next item is taken while the previous result waits in the output register.
// Reset clears the length and control; entries are not cleared, the length bounds every read.
module positional_list_engine_top
	import ple_pkg::*;
#(
	parameter int CAPACITY   = PLE_CAPACITY,
	parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         op,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [STAT_W-1:0]       status,
	output logic signed [VAL_W-1:0] out_value,
	output logic [POS_W-1:0]        found_position,
	output logic [POS_W-1:0]        list_length,
	output logic                    is_empty
);

	ple_cmd_t  cmd;
	ple_stat_t stat;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ple_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.op             (op),
		.position       (position),
		.value          (value),
		.status         (status),
		.out_value      (out_value),
		.found_position (found_position),
		.list_length    (list_length),
		.is_empty       (is_empty)
	);

endmodule

// ===== hw/rtl/ple_checker.sv =====
// Port-level checker of the positional list engine, bound to the top level.
module ple_checker
	import ple_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [STAT_W-1:0]       status,
	input logic signed [VAL_W-1:0] out_value,
	input logic [POS_W-1:0]        found_position,
	input logic [POS_W-1:0]        list_length,
	input logic                    is_empty
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(out_value)
			&& $stable(found_position) && $stable(list_length))
		else $error("stalled result item changed");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_empty == (list_length == '0))
		else $error("empty flag disagrees with length");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BADPOS || status == ST_FULL || status == ST_NOTFOUND)
			|-> out_value == '0 && found_position == '0)
		else $error("error result carries data");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (.*);

// ===== tb/positional_list_engine_top_test.sv =====
// Self-checking random testbench for the positional list engine: insert, delete, get, locate, clear.
module positional_list_engine_top_test
	import ple_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD      = 10;
	localparam int N_RANDOM    = 1250;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 60;
	localparam int HOLD_AFTER  = 150;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
	} list_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] data;
		logic [POS_W-1:0]        found;
		logic [POS_W-1:0]        len;
		logic                    empty;
	} list_resp_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         op = '0;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] out_value;
	logic [POS_W-1:0]        found_position;
	logic [POS_W-1:0]        list_length;
	logic                    is_empty;

	positional_list_engine_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.position       (position),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_value      (out_value),
		.found_position (found_position),
		.list_length    (list_length),
		.is_empty       (is_empty)
	);

	always #(PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------- list model
	logic [PLE_DATA_WIDTH-1:0] slots [PLE_CAPACITY];
	int                        fill = 0;
	int                        peak_fill = 0;

	function automatic list_resp_t apply_list_op(input list_cmd_t c);
		list_resp_t r;
		int         p;
		int         j;
		r = '0;
		r.status = ST_OK;
		p = int'(c.pos);
		case (c.op)
			OP_CLEAR: begin
				for (j = 0; j < PLE_CAPACITY; j++)
					slots[j] = '0;
				fill = 0;
			end
			OP_GET: begin
				if (p < 1 || p > fill)
					r.status = ST_BADPOS;
				else
					r.data = slots[p-1];
			end
			OP_LOCATE: begin
				r.status = ST_NOTFOUND;
				for (j = 0; j < fill; j++) begin
					if (slots[j] == c.val) begin
						r.found = POS_W'(j + 1);
						r.status = ST_OK;
						break;
					end
				end
			end
			OP_INSERT: begin
				if (fill >= PLE_CAPACITY) begin
					r.status = ST_FULL;
				end else if (p < 1 || p > fill + 1) begin
					r.status = ST_BADPOS;
				end else begin
					for (j = fill; j >= p; j--)
						slots[j] = slots[j-1];
					slots[p-1] = c.val;
					fill++;
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > fill) begin
					r.status = ST_BADPOS;
				end else begin
					r.data = slots[p-1];
					for (j = p - 1; j + 1 < fill; j++)
						slots[j] = slots[j+1];
					slots[fill-1] = '0;
					fill--;
				end
			end
			default: ;
		endcase
		if (fill > peak_fill)
			peak_fill = fill;
		r.len = POS_W'(fill);
		r.empty = (fill == 0);
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus plan
	list_cmd_t               plan_q [$];
	logic signed [VAL_W-1:0] pool [8];
	int                      plan_fill = 0;

	// Queue one item and track the length it leaves behind, to steer later positions.
	task automatic plan_item(input logic [OP_W-1:0] o, input int p, input logic [VAL_W-1:0] v);
		list_cmd_t c;
		c.op = o;
		c.pos = POS_W'(p);
		c.val = v;
		plan_q.push_back(c);
		p = int'(c.pos);
		case (o)
			OP_CLEAR: plan_fill = 0;
			OP_INSERT: if (plan_fill < PLE_CAPACITY && p >= 1 && p <= plan_fill + 1) plan_fill++;
			OP_DELETE: if (p >= 1 && p <= plan_fill) plan_fill--;
			default: ;
		endcase
	endtask

	task automatic plan_random();
		int                mode;
		int                burst;
		int                roll;
		int                hi;
		int                p;
		int                o;
		logic [OP_W-1:0]   sel;
		logic [VAL_W-1:0]  v;
		while (plan_q.size() < N_RANDOM) begin
			// fill-heavy, drain-heavy or balanced stretch
			mode = $urandom_range(0, 2);
			burst = $urandom_range(10, 60);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				v = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 7)] : $urandom;
				if (roll < 6) begin
					o = $urandom_range(0, (1 << OP_W) - 1);
					plan_item(OP_W'(o), $urandom_range(0, (1 << POS_W) - 1), $urandom);
				end else if (roll < 7) begin
					plan_item(OP_CLEAR, $urandom_range(0, 31), v);
				end else begin
					roll = $urandom_range(0, 99);
					case (mode)
						0: sel = (roll < 60) ? OP_INSERT : (roll < 75) ? OP_GET :
							(roll < 90) ? OP_LOCATE : OP_DELETE;
						1: sel = (roll < 55) ? OP_DELETE : (roll < 70) ? OP_INSERT :
							(roll < 85) ? OP_GET : OP_LOCATE;
						default: sel = (roll < 25) ? OP_INSERT : (roll < 50) ? OP_DELETE :
							(roll < 75) ? OP_GET : OP_LOCATE;
					endcase
					hi = (sel == OP_INSERT) ? plan_fill + 1 : plan_fill;
					if (hi == 0 || $urandom_range(0, 9) == 0)
						p = ($urandom_range(0, 1) == 0) ? 0 : hi + 1;
					else begin
						case ($urandom_range(0, 3))
							0: p = 1;
							1: p = hi;
							default: p = $urandom_range(1, hi);
						endcase
					end
					plan_item(sel, p, v);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- sender
	list_cmd_t head;
	int        gap_left = 0;
	int        burst_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
			burst_left = 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0 || plan_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				head = plan_q.pop_front();
				in_valid <= 1'b1;
				op <= head.op;
				position <= head.pos;
				value <= head.val;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver
	int   cycle = 0;
	int   stall_mode = 0;
	int   stall_epoch = 0;
	logic holding = 1'b0;
	logic hold_done = 1'b0;
	int   hold_cnt = 0;
	int   n_accepted = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_epoch == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_epoch = $urandom_range(50, 400);
			end else begin
				stall_epoch--;
			end
			case (stall_mode)
				0: out_ready <= !holding;
				1: out_ready <= (cycle % 9 >= 4) && !holding;
				default: out_ready <= ($urandom_range(0, 99) >= 35) && !holding;
			endcase
		end
	end

	// One long hold-off so the engine backs up and drops in_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			if (hold_cnt == 1)
				holding <= 1'b0;
		end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
			holding <= 1'b1;
			hold_done <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items accepted", cycle, n_accepted);
			$display("positional_list_engine_top_test: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- checker
	list_resp_t want_q [$];
	list_resp_t want;
	list_resp_t got;
	list_cmd_t  taken;
	int         n_errors = 0;
	int         n_results = 0;
	int         op_count [1 << OP_W];
	int         st_count [1 << STAT_W];

	task automatic flag_error(input string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("ERROR: %s", msg);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				taken = '{op: op, pos: position, val: value};
				want_q.push_back(apply_list_op(taken));
				op_count[op]++;
				n_accepted <= n_accepted + 1;
			end
			if (out_valid && out_ready) begin
				got = '{status: status, data: out_value, found: found_position,
					len: list_length, empty: is_empty};
				n_results <= n_results + 1;
				if (want_q.size() == 0) begin
					flag_error($sformatf("result with nothing pending: st=%0d val=%0h pos=%0d len=%0d",
						got.status, got.data, got.found, got.len));
				end else begin
					want = want_q.pop_front();
					st_count[want.status]++;
					if (got !== want)
						flag_error($sformatf({"result %0d: exp st=%0d val=%h pos=%0d len=%0d emp=%0b, ",
							"got st=%0d val=%h pos=%0d len=%0d emp=%0b"}, n_results,
							want.status, want.data, want.found, want.len, want.empty,
							got.status, got.data, got.found, got.len, got.empty));
				end
			end
		end
	end

	// ---------------------------------------------------------------- run control
	int n_total;
	int o;

	initial begin
		for (o = 0; o < PLE_CAPACITY; o++)
			slots[o] = '0;
		for (o = 0; o < (1 << OP_W); o++)
			op_count[o] = 0;
		for (o = 0; o < (1 << STAT_W); o++)
			st_count[o] = 0;
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		pool[2] = '0;
		pool[3] = '1;
		for (o = 4; o < 8; o++)
			pool[o] = $urandom;

		// directed opening: empty-list errors, edge values, edge positions, unused codes
		plan_item(OP_CLEAR, 0, '0);
		plan_item(OP_GET, 0, '0);
		plan_item(OP_DELETE, 1, '0);
		plan_item(OP_LOCATE, 0, '0);
		plan_item(OP_INSERT, 0, 32'd5);
		plan_item(OP_INSERT, 2, 32'd5);
		plan_item(OP_INSERT, 1, 32'h8000_0000);
		plan_item(OP_INSERT, 2, 32'h7FFF_FFFF);
		plan_item(OP_INSERT, 1, '1);
		plan_item(OP_GET, 3, '0);
		plan_item(OP_LOCATE, 0, 32'h7FFF_FFFF);
		plan_item(OP_LOCATE, 0, 32'd12345);
		plan_item(OP_GET, 31, '0);
		plan_item(OP_INSERT, 5, 32'd7);
		plan_item(OP_INSERT, 4, '0);
		plan_item(OP_DELETE, 2, '0);
		for (o = OP_DELETE + 1; o < (1 << OP_W); o++)
			plan_item(OP_W'(o), 31, '1);
		plan_item(OP_DELETE, 3, '0);
		plan_item(OP_DELETE, 0, '0);
		plan_random();
		n_total = plan_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == n_total && want_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (want_q.size() != 0)
			flag_error($sformatf("%0d results never arrived", want_q.size()));

		$display("ran %0d items: clear %0d, get %0d, locate %0d, insert %0d, delete %0d, unused %0d",
			n_accepted, op_count[OP_CLEAR], op_count[OP_GET], op_count[OP_LOCATE],
			op_count[OP_INSERT], op_count[OP_DELETE],
			n_accepted - op_count[OP_CLEAR] - op_count[OP_GET] - op_count[OP_LOCATE]
			- op_count[OP_INSERT] - op_count[OP_DELETE]);
		$display("outcomes: bad position %0d, full %0d, not found %0d; longest list %0d; errors %0d",
			st_count[ST_BADPOS], st_count[ST_FULL], st_count[ST_NOTFOUND], peak_fill, n_errors);
		if (n_errors == 0)
			$display("positional_list_engine_top_test: PASS");
		else
			$display("positional_list_engine_top_test: FAIL");
		$finish;
	end

endmodule
